>>> src/sfm_pkg.sv
// Shared constants for the median score fusion block.
`default_nettype none

package sfm_pkg;

  // Number of score fields that a row carries on the input channel.
  localparam int NUM_FIELDS = 8;

  // Default number of score columns that the block sorts.
  localparam int MAX_SCORES_DEFAULT = 8;

  // Default width of one signed Q16.16 score.
  localparam int SCORE_WIDTH_DEFAULT = 32;

  // Width of the presence mask on the input channel.
  localparam int MASK_WIDTH = 8;

  // Width and reset value of the num_scores register.
  localparam int CFG_WIDTH = 4;
  localparam logic [CFG_WIDTH-1:0] NUM_SCORES_RESET = 4'd8;

endpackage

`default_nettype wire

>>> src/sfm_ifs.sv
// Handshake channel interfaces for score rows and median results.
`default_nettype none

interface score_row_if #(
  parameter int SCORE_WIDTH = sfm_pkg::SCORE_WIDTH_DEFAULT
);
  logic                                   valid;
  logic                                   ready;
  logic [sfm_pkg::MASK_WIDTH-1:0]         present_mask;
  logic signed [SCORE_WIDTH-1:0]          score_0;
  logic signed [SCORE_WIDTH-1:0]          score_1;
  logic signed [SCORE_WIDTH-1:0]          score_2;
  logic signed [SCORE_WIDTH-1:0]          score_3;
  logic signed [SCORE_WIDTH-1:0]          score_4;
  logic signed [SCORE_WIDTH-1:0]          score_5;
  logic signed [SCORE_WIDTH-1:0]          score_6;
  logic signed [SCORE_WIDTH-1:0]          score_7;

  modport source (
    output valid, present_mask, score_0, score_1, score_2, score_3,
           score_4, score_5, score_6, score_7,
    input  ready
  );

  modport sink (
    input  valid, present_mask, score_0, score_1, score_2, score_3,
           score_4, score_5, score_6, score_7,
    output ready
  );
endinterface

interface median_if #(
  parameter int SCORE_WIDTH = sfm_pkg::SCORE_WIDTH_DEFAULT
);
  logic                          valid;
  logic                          ready;
  logic signed [SCORE_WIDTH-1:0] median;

  modport source (output valid, median, input ready);
  modport sink (input valid, median, output ready);
endinterface

`default_nettype wire

>>> src/sfm_sort_cell.sv
// One compare-exchange layer of the odd-even transposition sorter, registered.
`default_nettype none

module sfm_sort_cell #(
  parameter int MAX_SCORES = sfm_pkg::MAX_SCORES_DEFAULT,
  parameter int KEY_WIDTH  = sfm_pkg::SCORE_WIDTH_DEFAULT + 1,
  parameter int PARITY     = 0
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [MAX_SCORES-1:0][KEY_WIDTH-1:0]  in_keys,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [MAX_SCORES-1:0][KEY_WIDTH-1:0]       out_keys
);

  logic [MAX_SCORES-1:0][KEY_WIDTH-1:0] keys_next;

  // The stage takes a new row when it is empty or its row moves on.
  assign in_ready = !out_valid || out_ready;

  // Neighbor pairs of this layer's parity are swapped when out of order.
  for (genvar i = 0; i < MAX_SCORES; i++) begin : g_slot
    if ((i % 2) == PARITY && (i + 1) < MAX_SCORES) begin : g_low
      assign keys_next[i] = ($signed(in_keys[i]) > $signed(in_keys[i+1])) ?
                            in_keys[i+1] : in_keys[i];
    end else if ((i % 2) != PARITY && i > 0) begin : g_high
      assign keys_next[i] = ($signed(in_keys[i-1]) > $signed(in_keys[i])) ?
                            in_keys[i-1] : in_keys[i];
    end else begin : g_pass
      assign keys_next[i] = in_keys[i];
    end
  end

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Row payload, loaded on each transfer into the stage.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_keys <= keys_next;
    end
  end

endmodule

`default_nettype wire

>>> src/sfm_median_pick.sv
// Picks the middle values of a sorted row and forms the floored median.
`default_nettype none

module sfm_median_pick #(
  parameter int MAX_SCORES  = sfm_pkg::MAX_SCORES_DEFAULT,
  parameter int SCORE_WIDTH = sfm_pkg::SCORE_WIDTH_DEFAULT,
  parameter int CNT_WIDTH   = $clog2(MAX_SCORES + 1)
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      in_valid,
  output logic                                           in_ready,
  input  wire logic [MAX_SCORES-1:0][SCORE_WIDTH:0]      in_keys,
  input  wire logic [CNT_WIDTH-1:0]                      num_used,
  output logic                                           out_valid,
  input  wire logic                                      out_ready,
  output logic signed [SCORE_WIDTH-1:0]                  median
);

  localparam int IDX_WIDTH = (MAX_SCORES > 1) ? $clog2(MAX_SCORES) : 1;

  logic [CNT_WIDTH-1:0]          lo_cnt;
  logic [CNT_WIDTH-1:0]          hi_cnt;
  logic [IDX_WIDTH-1:0]          lo_idx;
  logic [IDX_WIDTH-1:0]          hi_idx;
  logic signed [SCORE_WIDTH-1:0] lo_val;
  logic signed [SCORE_WIDTH-1:0] hi_val;
  logic signed [SCORE_WIDTH:0]   pair_sum;
  logic signed [SCORE_WIDTH-1:0] median_next;

  assign in_ready = !out_valid || out_ready;

  // The middle slots are (n-1)/2 and n/2; they coincide for an odd count.
  assign lo_cnt = (num_used - CNT_WIDTH'(1)) >> 1;
  assign hi_cnt = num_used >> 1;
  assign lo_idx = IDX_WIDTH'(lo_cnt);
  assign hi_idx = IDX_WIDTH'(hi_cnt);

  // Used slots hold real scores, so the low bits carry the full value.
  assign lo_val = in_keys[lo_idx][SCORE_WIDTH-1:0];
  assign hi_val = in_keys[hi_idx][SCORE_WIDTH-1:0];

  // Sum at one extra bit, then an arithmetic shift floors the halving.
  assign pair_sum = {lo_val[SCORE_WIDTH-1], lo_val} + {hi_val[SCORE_WIDTH-1], hi_val};

  always_comb begin
    if (num_used == '0) begin
      median_next = '0;
    end else begin
      median_next = pair_sum[SCORE_WIDTH:1];
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      median <= median_next;
    end
  end

endmodule

`default_nettype wire

>>> src/score_fusion_median.sv
// Top level of the median score fusion block.
`default_nettype none

// Median score fusion: each row of up to MAX_SCORES signed scores passes
// through a chain of MAX_SCORES registered compare-exchange cells
// (odd-even transposition sort) and a registered median picker. One row is
// accepted per clock cycle while the first cell has room, and the row is
// registered by each sort cell in turn and then by the picker. Each stage
// holds one row and moves it on as soon as the next stage has room, so the
// input keeps taking rows while a result waits at the output until every
// stage holds a row. Absent scores count as zero; slots beyond num_scores
// are filled with a value above every score so that they sort to the top
// and are never picked. The num_scores register (reset 8, saturating at
// MAX_SCORES) should only be written while no row is in flight.
module score_fusion_median #(
  parameter int MAX_SCORES  = sfm_pkg::MAX_SCORES_DEFAULT,
  parameter int SCORE_WIDTH = sfm_pkg::SCORE_WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [sfm_pkg::CFG_WIDTH-1:0] cfg_data,
  score_row_if.sink                          row_in,
  median_if.source                           median_out
);

  localparam int KEY_WIDTH = SCORE_WIDTH + 1;
  localparam int CNT_WIDTH = $clog2(MAX_SCORES + 1);
  localparam logic [KEY_WIDTH-1:0] KEY_FILL = {1'b0, {SCORE_WIDTH{1'b1}}};

  logic [sfm_pkg::CFG_WIDTH-1:0]                 num_scores;
  logic [CNT_WIDTH-1:0]                          num_used;
  logic [sfm_pkg::NUM_FIELDS-1:0][SCORE_WIDTH-1:0] fields;
  logic [MAX_SCORES-1:0][KEY_WIDTH-1:0]          row_keys;

  logic [MAX_SCORES:0]                           stage_valid;
  logic [MAX_SCORES:0]                           stage_ready;
  logic [MAX_SCORES:0][MAX_SCORES-1:0][KEY_WIDTH-1:0] stage_keys;

  // Score count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_scores <= sfm_pkg::NUM_SCORES_RESET;
    end else if (cfg_we) begin
      num_scores <= cfg_data;
    end
  end

  // Counts above the number of columns saturate.
  assign num_used = (num_scores > sfm_pkg::CFG_WIDTH'(MAX_SCORES)) ?
                    CNT_WIDTH'(MAX_SCORES) : num_scores[CNT_WIDTH-1:0];

  assign fields[0] = row_in.score_0;
  assign fields[1] = row_in.score_1;
  assign fields[2] = row_in.score_2;
  assign fields[3] = row_in.score_3;
  assign fields[4] = row_in.score_4;
  assign fields[5] = row_in.score_5;
  assign fields[6] = row_in.score_6;
  assign fields[7] = row_in.score_7;

  // Build sort keys: sign-extended score, zero when absent, fill when unused.
  for (genvar i = 0; i < MAX_SCORES; i++) begin : g_key
    always_comb begin
      if (num_used <= CNT_WIDTH'(i)) begin
        row_keys[i] = KEY_FILL;
      end else if (row_in.present_mask[i]) begin
        row_keys[i] = {fields[i][SCORE_WIDTH-1], fields[i]};
      end else begin
        row_keys[i] = '0;
      end
    end
  end

  assign stage_valid[0] = row_in.valid;
  assign row_in.ready   = stage_ready[0];
  assign stage_keys[0]  = row_keys;

  // Chain of sorting cells with alternating pair parity.
  for (genvar s = 0; s < MAX_SCORES; s++) begin : g_cell
    sfm_sort_cell #(
      .MAX_SCORES (MAX_SCORES),
      .KEY_WIDTH  (KEY_WIDTH),
      .PARITY     (s % 2)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[s]),
      .in_ready  (stage_ready[s]),
      .in_keys   (stage_keys[s]),
      .out_valid (stage_valid[s+1]),
      .out_ready (stage_ready[s+1]),
      .out_keys  (stage_keys[s+1])
    );
  end

  // Median selection and output register.
  sfm_median_pick #(
    .MAX_SCORES  (MAX_SCORES),
    .SCORE_WIDTH (SCORE_WIDTH),
    .CNT_WIDTH   (CNT_WIDTH)
  ) u_pick (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[MAX_SCORES]),
    .in_ready  (stage_ready[MAX_SCORES]),
    .in_keys   (stage_keys[MAX_SCORES]),
    .num_used  (num_used),
    .out_valid (median_out.valid),
    .out_ready (median_out.ready),
    .median    (median_out.median)
  );

endmodule

`default_nettype wire
